FILE: rtl/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define AST_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define AST_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/e2cd_pkg.sv
// package: constants, microcode types and control store for the epoch to date core
`timescale 1ns / 1ps

package e2cd_pkg;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned DaysPerQuad = 1461;
	localparam int unsigned BaseYear    = 1970;
	localparam logic [31:0] LAST_EPOCH  = 32'd4102444799;

	localparam int PC_W = 4;
	localparam int LC_W = 4;

	// micro-operations of the datapath
	typedef enum logic [2:0] {
		OP_DIV   = 3'd0,  // one restoring division step, divisor shifted by loop count
		OP_SDAY  = 3'd1,  // save day count, clear quotient
		OP_HOUR  = 3'd2,  // store hour, clear quotient
		OP_MIN   = 3'd3,  // store minute and second, reload day count
		OP_QUAD  = 3'd4,  // year from four-year cycles
		OP_YEAR  = 3'd5,  // peel one year or fall through
		OP_MON   = 3'd6,  // peel one month or fall through
		OP_DONE  = 3'd7   // hand result to output register
	} op_t;

	typedef enum logic [1:0] {
		DS_DAY  = 2'd0,
		DS_HOUR = 2'd1,
		DS_MIN  = 2'd2,
		DS_QUAD = 2'd3
	} dsel_t;

	typedef struct packed {
		op_t              op;
		dsel_t            dsel;
		logic [LC_W-1:0]  cnt;
	} uword_t;

	localparam logic [PC_W-1:0] PC_DONE = 4'd10;

	// control store
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_DONE, dsel: DS_DAY, cnt: 4'd0};
		unique case (pc)
			4'd0:    w = '{op: OP_DIV,  dsel: DS_DAY,  cnt: 4'd15};
			4'd1:    w = '{op: OP_SDAY, dsel: DS_DAY,  cnt: 4'd0};
			4'd2:    w = '{op: OP_DIV,  dsel: DS_HOUR, cnt: 4'd4};
			4'd3:    w = '{op: OP_HOUR, dsel: DS_DAY,  cnt: 4'd0};
			4'd4:    w = '{op: OP_DIV,  dsel: DS_MIN,  cnt: 4'd5};
			4'd5:    w = '{op: OP_MIN,  dsel: DS_DAY,  cnt: 4'd0};
			4'd6:    w = '{op: OP_DIV,  dsel: DS_QUAD, cnt: 4'd5};
			4'd7:    w = '{op: OP_QUAD, dsel: DS_DAY,  cnt: 4'd0};
			4'd8:    w = '{op: OP_YEAR, dsel: DS_DAY,  cnt: 4'd0};
			4'd9:    w = '{op: OP_MON,  dsel: DS_DAY,  cnt: 4'd0};
			default: w = '{op: OP_DONE, dsel: DS_DAY,  cnt: 4'd0};
		endcase
		return w;
	endfunction

	// unshifted divisor for each division phase
	function automatic logic [31:0] divisor(input dsel_t sel);
		logic [31:0] d;
		d = 32'(SecsPerDay);
		unique case (sel)
			DS_DAY:  d = 32'(SecsPerDay);
			DS_HOUR: d = 32'(SecsPerHour);
			DS_MIN:  d = 32'(SecsPerMin);
			DS_QUAD: d = 32'(DaysPerQuad);
			default: d = 32'(SecsPerDay);
		endcase
		return d;
	endfunction

	// days in month, index 0 is january
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		len = 5'd31;
		case (m)
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: rtl/epoch_to_calendar_date_core.sv
// top level: microcoded conversion of epoch seconds to utc calendar date and time
`timescale 1ns / 1ps

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into year, month,
// day, hour, minute and second, valid through the end of 2099; larger counts give
// zeros with the range flag (tuser) set. One item is in conversion at a time. A
// microcode program drives a single subtract-and-compare unit: restoring division
// by 86400, 3600, 60 and 1461 (four-year cycles), then one year or one month peeled
// per cycle. The time from acceptance until a result is offered depends on the year and
// month loops; an out-of-range count skips straight to the done step. A finished result
// sits in an output register, and the next item can be accepted in the cycle after the
// previous result is written there.

`include "assert_macros.svh"

module epoch_to_calendar_date_core
	import e2cd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // epoch_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // year[11:0], month, day, hour, minute, second, 2 zero bits
	output logic        m_axis_tuser    // range_error
);

	// sequencer state
	logic              busy_q;
	logic [PC_W-1:0]   pc_q;
	logic [LC_W-1:0]   lc_q;
	logic              err_q;

	// datapath registers
	logic [31:0]       a_q;
	logic [15:0]       q_q;
	logic [15:0]       day_q;
	logic [11:0]       year_q;
	logic [3:0]        mon_q;
	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [5:0]        second_q;

	// output register
	logic              m_valid_q;
	logic [37:0]       m_data_q;
	logic              m_err_q;

	uword_t            uw;
	uword_t            uw_next;
	uword_t            uw_first;
	logic [31:0]       sub_val;
	logic [32:0]       diff;
	logic              ge;
	logic              leap;
	logic [8:0]        year_len;
	logic [4:0]        mlen;
	logic              out_free;
	logic              out_load;
	logic              s_accept;

	assign uw       = ucode(pc_q);
	assign uw_next  = ucode(pc_q + 4'd1);
	assign uw_first = ucode('0);
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = busy_q && (uw.op == OP_DONE) && out_free;

	// shared subtract-and-compare unit
	always_comb begin
		leap     = (year_q[1:0] == 2'b00);
		year_len = leap ? 9'd366 : 9'd365;
		mlen     = month_len(mon_q, leap);
		sub_val  = divisor(uw.dsel) << lc_q;
		case (uw.op)
			OP_YEAR: sub_val = 32'(year_len);
			OP_MON:  sub_val = 32'(mlen);
			default: sub_val = divisor(uw.dsel) << lc_q;
		endcase
		diff = {1'b0, a_q} - {1'b0, sub_val};
		ge   = !diff[32];
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pc_q      <= '0;
			lc_q      <= '0;
			err_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (s_accept) begin
					busy_q <= 1'b1;
					a_q    <= s_axis_tdata;
					q_q    <= '0;
					err_q  <= (s_axis_tdata > LAST_EPOCH);
					if (s_axis_tdata > LAST_EPOCH) begin
						pc_q <= PC_DONE;
					end else begin
						pc_q <= '0;
						lc_q <= uw_first.cnt;
					end
				end
			end else begin
				unique case (uw.op)
					OP_DIV: begin
						if (ge) begin
							a_q <= diff[31:0];
						end
						q_q <= {q_q[14:0], ge};
						if (lc_q == '0) begin
							pc_q <= pc_q + 4'd1;
							lc_q <= uw_next.cnt;
						end else begin
							lc_q <= lc_q - 4'd1;
						end
					end
					OP_SDAY: begin
						day_q <= q_q;
						q_q   <= '0;
						pc_q  <= pc_q + 4'd1;
						lc_q  <= uw_next.cnt;
					end
					OP_HOUR: begin
						hour_q <= q_q[4:0];
						q_q    <= '0;
						pc_q   <= pc_q + 4'd1;
						lc_q   <= uw_next.cnt;
					end
					OP_MIN: begin
						minute_q <= q_q[5:0];
						second_q <= a_q[5:0];
						a_q      <= 32'(day_q);
						q_q      <= '0;
						pc_q     <= pc_q + 4'd1;
						lc_q     <= uw_next.cnt;
					end
					OP_QUAD: begin
						year_q <= 12'(BaseYear) + {4'd0, q_q[5:0], 2'b00};
						mon_q  <= '0;
						pc_q   <= pc_q + 4'd1;
						lc_q   <= uw_next.cnt;
					end
					OP_YEAR: begin
						if (ge) begin
							a_q    <= diff[31:0];
							year_q <= year_q + 12'd1;
						end else begin
							pc_q <= pc_q + 4'd1;
							lc_q <= uw_next.cnt;
						end
					end
					OP_MON: begin
						if (ge && mon_q != 4'd11) begin
							a_q   <= diff[31:0];
							mon_q <= mon_q + 4'd1;
						end else begin
							pc_q <= pc_q + 4'd1;
							lc_q <= uw_next.cnt;
						end
					end
					OP_DONE: begin
						if (out_free) begin
							m_err_q   <= err_q;
							busy_q    <= 1'b0;
							if (err_q) begin
								m_data_q <= '0;
							end else begin
								m_data_q <= {second_q, minute_q, hour_q, a_q[4:0] + 5'd1,
									mon_q + 4'd1, year_q};
							end
						end
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// ports
	assign s_axis_tready = !busy_q;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_data_q};
	assign m_axis_tuser  = m_err_q;

	// checks
	`AST_HOLDS(a_err_zero, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata == 40'd0),
		"range error with nonzero date")
	`AST_HOLDS(a_month_ok, !(m_axis_tvalid && !m_axis_tuser)
		|| (m_axis_tdata[15:12] != 4'd0 && m_axis_tdata[15:12] <= 4'd12), "month out of range")
	`AST_HOLDS(a_mon_idx, !busy_q || mon_q <= 4'd11 || uw.op == OP_DIV || uw.op == OP_SDAY
		|| uw.op == OP_HOUR || uw.op == OP_MIN || uw.op == OP_QUAD, "month index past december")
	`AST_NEXT(a_busy_after, s_accept, !s_axis_tready, "ready after accept")

endmodule

FILE: bench/testbench.sv
// testbench for the epoch seconds to calendar date and time core
`timescale 1ns / 1ps

module testbench;

	localparam logic [31:0] EPOCH_END   = 32'd4102444799;  // 2099-12-31 23:59:59
	localparam int          DRAIN_AT    = 250;   // sender waits for all dates here
	localparam int          HOLD_AT     = 100;   // receiver holds off here
	localparam int          LONG_HOLD   = 300;
	localparam int          CALM_FIRST  = 350;   // window with no idling on either side
	localparam int          CALM_LAST   = 470;
	localparam int          N_RANDOM    = 600;
	localparam int          TAIL_CYCLES = 120;

	// one converted date, in the core's output field widths
	typedef struct {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        range_error;
	} date_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	logic [31:0] epochs_to_send[$];
	date_t       dates_due[$];
	date_t       want, got;
	int          n_epochs_in = 0;
	int          n_dates_out = 0;
	int          n_fail = 0;
	bit          item_taken = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	epoch_to_calendar_date_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic bit leap_year(input int unsigned yr);
		return (yr % 4) == 0;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
		int unsigned len;
		case (mo)
			2:              len = leap_year(yr) ? 29 : 28;
			4, 6, 9, 11:    len = 30;
			default:        len = 31;
		endcase
		return len;
	endfunction

	// seconds since 1970 for a calendar date and time
	function automatic logic [31:0] epoch_of(input int unsigned yr, input int unsigned mo,
			input int unsigned dy, input int unsigned hr, input int unsigned mi,
			input int unsigned sc);
		int unsigned total;
		int unsigned k;
		total = 0;
		for (k = 1970; k < yr; k++)
			total += leap_year(k) ? 366 : 365;
		for (k = 1; k < mo; k++)
			total += days_in_month(yr, k);
		total += dy - 1;
		return 32'(total * 86400 + hr * 3600 + mi * 60 + sc);
	endfunction

	// expected date for one epoch count
	function automatic date_t calendar_of(input logic [31:0] secs);
		date_t       d;
		int unsigned days, rem, yr, mo, len;
		d = '{default: '0};
		if (secs > EPOCH_END) begin
			d.range_error = 1'b1;
			return d;
		end
		days = secs / 86400;
		rem  = secs % 86400;
		yr = 1970;
		forever begin
			len = leap_year(yr) ? 366 : 365;
			if (days < len)
				break;
			days -= len;
			yr++;
		end
		mo = 1;
		while (mo < 12 && days >= days_in_month(yr, mo)) begin
			days -= days_in_month(yr, mo);
			mo++;
		end
		d.year   = 12'(yr);
		d.month  = 4'(mo);
		d.day    = 5'(days + 1);
		d.hour   = 5'(rem / 3600);
		d.minute = 6'((rem % 3600) / 60);
		d.second = 6'(rem % 60);
		return d;
	endfunction

	task automatic report_failure(input string what);
		if (n_fail < 10)
			$display("[%0t] %s", $realtime, what);
		n_fail++;
	endtask

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// handshakes seen at the rising edge: log accepted epochs, check returned dates
	always @(posedge clk) begin
		item_taken = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				dates_due.push_back(calendar_of(s_axis_tdata));
				void'(epochs_to_send.pop_front());
				n_epochs_in++;
				item_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.year        = m_axis_tdata[11:0];
				got.month       = m_axis_tdata[15:12];
				got.day         = m_axis_tdata[20:16];
				got.hour        = m_axis_tdata[25:21];
				got.minute      = m_axis_tdata[31:26];
				got.second      = m_axis_tdata[37:32];
				got.range_error = m_axis_tuser;
				if (dates_due.size() == 0) begin
					report_failure($sformatf("unexpected date %0d-%0d-%0d %0d:%0d:%0d err %0b",
						got.year, got.month, got.day, got.hour, got.minute, got.second,
						got.range_error));
				end else begin
					want = dates_due.pop_front();
					if (got.year !== want.year || got.month !== want.month
							|| got.day !== want.day || got.hour !== want.hour
							|| got.minute !== want.minute || got.second !== want.second
							|| got.range_error !== want.range_error)
						report_failure($sformatf(
							"date %0d: expected %0d-%0d-%0d %0d:%0d:%0d err %0b, got %0d-%0d-%0d %0d:%0d:%0d err %0b",
							n_dates_out, want.year, want.month, want.day, want.hour,
							want.minute, want.second, want.range_error, got.year, got.month,
							got.day, got.hour, got.minute, got.second, got.range_error));
				end
				n_dates_out++;
			end
		end
	end

	// sender: holds an offered epoch until taken, idles at random, pauses once to drain
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || item_taken) begin
			if (epochs_to_send.size() > 0
					&& !(n_epochs_in == DRAIN_AT && dates_due.size() != 0)
					&& ((n_epochs_in >= CALM_FIRST && n_epochs_in < CALM_LAST)
						|| $urandom_range(99, 0) >= 7)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= epochs_to_send[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && n_dates_out >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (n_dates_out >= CALM_FIRST && n_dates_out < CALM_LAST)
				|| $urandom_range(99, 0) >= 7;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned yr, mo, dy, pick;
		logic [31:0] e;

		// directed: range ends, 2038 rollover, leap days, every month end
		epochs_to_send.push_back(32'd0);
		epochs_to_send.push_back(32'h7FFF_FFFF);
		epochs_to_send.push_back(32'h8000_0000);
		epochs_to_send.push_back(EPOCH_END);
		epochs_to_send.push_back(EPOCH_END + 32'd1);
		epochs_to_send.push_back(32'hFFFF_FFFF);
		epochs_to_send.push_back(epoch_of(1972, 2, 28, 23, 59, 59));
		epochs_to_send.push_back(epoch_of(1972, 2, 29, 0, 0, 0));
		epochs_to_send.push_back(epoch_of(1972, 12, 31, 23, 59, 59));
		epochs_to_send.push_back(epoch_of(2000, 2, 29, 12, 34, 56));
		epochs_to_send.push_back(epoch_of(2096, 2, 29, 23, 59, 59));
		for (mo = 1; mo <= 12; mo++)
			epochs_to_send.push_back(epoch_of(1999, mo, days_in_month(1999, mo), 23, 59, 59));

		// random: mostly in range, many on month and year edges, some out of range
		repeat (N_RANDOM) begin
			pick = $urandom_range(99, 0);
			if (pick < 45) begin
				e = $urandom_range(EPOCH_END, 0);
			end else if (pick < 80) begin
				yr = $urandom_range(2099, 1970);
				mo = $urandom_range(12, 1);
				dy = $urandom_range(1, 0) ? days_in_month(yr, mo) : 1;
				case ($urandom_range(2, 0))
					0:       e = epoch_of(yr, mo, dy, 0, 0, 0);
					1:       e = epoch_of(yr, mo, dy, 23, 59, 59);
					default: e = epoch_of(yr, mo, dy, $urandom_range(23, 0),
						$urandom_range(59, 0), $urandom_range(59, 0));
				endcase
			end else if (pick < 90) begin
				e = $urandom_range(32'hFFFF_FFFF, EPOCH_END + 32'd1);
			end else begin
				e = $urandom();
			end
			epochs_to_send.push_back(e);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (epochs_to_send.size() != 0 || dates_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
